[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

[src/wnm_pkg.sv]
// ----------------------------------------------------------------------------
// wnm_pkg
// shared types and constants of the wildcard name matcher
// ----------------------------------------------------------------------------
package wnm_pkg;

   localparam int TEXT_MAX_DEF    = 64;
   localparam int PATTERN_MAX_DEF = 32;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int PAT_LEN_W  = 6;
   localparam int PAT_BITS   = 256;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_QUEST  = 8'h3F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic                 enable;
      logic [PAT_LEN_W-1:0] length;
      logic [PAT_BITS-1:0]  chars;
   } pattern_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

[src/wnm_csr.sv]
// ----------------------------------------------------------------------------
// wnm_csr
// configuration register file: mask enable, pattern length, pattern chars
// ----------------------------------------------------------------------------
module wnm_csr
   import wnm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pattern_type           pattern
);

   localparam logic [2:0] REG_MASK_ENABLED   = 3'd0;
   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
   localparam logic [2:0] REG_CHARS_A        = 3'd2;
   localparam logic [2:0] REG_CHARS_B        = 3'd3;
   localparam logic [2:0] REG_CHARS_C        = 3'd4;
   localparam logic [2:0] REG_CHARS_D        = 3'd5;

   logic                  enable_ff, enable_in;
   logic [PAT_LEN_W-1:0]  length_ff, length_in;
   logic [PAT_BITS-1:0]   chars_ff,  chars_in;
   logic [2:0]            reg_index;
   logic                  wr_en;

   assign reg_index  = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      length_in = length_ff;
      chars_in  = chars_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_MASK_ENABLED:   enable_in = csr_pwdata[0];
            REG_PATTERN_LENGTH: length_in = csr_pwdata[PAT_LEN_W-1:0];
            REG_CHARS_A:        chars_in[63:0]    = csr_pwdata;
            REG_CHARS_B:        chars_in[127:64]  = csr_pwdata;
            REG_CHARS_C:        chars_in[191:128] = csr_pwdata;
            REG_CHARS_D:        chars_in[255:192] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         length_ff <= '0;
         chars_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         length_ff <= length_in;
         chars_ff  <= chars_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MASK_ENABLED:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, enable_ff};
         REG_PATTERN_LENGTH: csr_prdata = {{(CSR_DATA_W-PAT_LEN_W){1'b0}}, length_ff};
         REG_CHARS_A:        csr_prdata = chars_ff[63:0];
         REG_CHARS_B:        csr_prdata = chars_ff[127:64];
         REG_CHARS_C:        csr_prdata = chars_ff[191:128];
         REG_CHARS_D:        csr_prdata = chars_ff[255:192];
         default:            csr_prdata = '0;
      endcase
   end

   assign pattern.enable = enable_ff;
   assign pattern.length = length_ff;
   assign pattern.chars  = chars_ff;

endmodule

[src/wildcard_name_matcher_core.sv]
// ----------------------------------------------------------------------------
// wildcard_name_matcher_core
// buffers a candidate string and matches it against a wildcard pattern
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one string byte per transaction; bytes load one per cycle
//   into the text memory while idle. a zero byte closes the string and starts a match.
//   rsp_* carries one transaction per string: matched and overflow.
//   csr_* is an apb port holding the pattern; write it only while idle.
// matching:
//   each matcher step reads the text memory in ST_FETCH, then evaluates in
//   ST_EVAL; steps grow with backtracking over the last star. overflow or a
//   disabled mask skips the matcher and goes from ST_IDLE straight to ST_PUT.
//   req_tready is low while a match runs or a result waits in ST_PUT.
// reset:
//   synchronous, clears the pattern registers, the text count and the
//   output valid; the text memory keeps its contents and needs no clearing.
// stalls:
//   a held result does not block loading of the next string; a finished
//   match waits in place until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_name_matcher_core
   import wnm_pkg::*;
#(
   parameter int TEXT_MAX    = TEXT_MAX_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] text_char
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] matched, [1] overflow, [7:2] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int TW = $clog2(TEXT_MAX + 1);
   localparam int AW = $clog2(TEXT_MAX);
   localparam int PW = $clog2(PATTERN_MAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_PUT   = 4'b1000
   } state_type;

   function automatic logic [7:0] pat_char(input logic [PAT_BITS-1:0] chars,
                                            input logic [PAT_LEN_W-1:0] lim,
                                            input logic [PW-1:0] idx);
      logic [7:0] c;
      c = CHAR_NUL;
      if (PAT_LEN_W'(idx) < lim) begin
         c = chars[8*int'(5'(idx)) +: 8];
      end
      return c;
   endfunction

   pattern_type pattern;

   state_type      state_ff, state_in;
   logic [TW-1:0]  count_ff, count_in;
   logic           too_long_ff, too_long_in;
   logic [PW-1:0]  pp_ff, pp_in;
   logic [TW-1:0]  tp_ff, tp_in;
   logic [PW-1:0]  spp_ff, spp_in;
   logic [TW-1:0]  stp_ff, stp_in;
   logic           star_seen_ff, star_seen_in;
   logic           aw_ff, aw_in;
   logic           res_match_ff, res_match_in;
   logic           res_ovf_ff, res_ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_match_ff, rsp_ovf_ff;
   logic [7:0]     text_rd_ff;

   logic [7:0]     text_mem [TEXT_MAX];

   logic [PAT_LEN_W-1:0] lim;
   logic [PW-1:0]  pp_plus;
   logic [7:0]     pc, qc, epc, tc;
   logic [PW-1:0]  epp;
   logic           text_left;
   logic           mismatch;
   logic           mem_we;
   logic           rsp_load;

   wnm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pattern     (pattern)
   );

   assign lim = (pattern.length > PAT_LEN_W'(PATTERN_MAX)) ?
                PAT_LEN_W'(PATTERN_MAX) : pattern.length;
   assign pp_plus   = pp_ff + 1'b1;
   assign pc        = pat_char(pattern.chars, lim, pp_ff);
   assign qc        = pat_char(pattern.chars, lim, pp_plus);
   assign epc       = (pc == CHAR_BSLASH) ? qc : pc;
   assign epp       = (pc == CHAR_BSLASH) ? pp_plus : pp_ff;
   assign text_left = tp_ff < count_ff;
   assign tc        = text_left ? text_rd_ff : CHAR_NUL;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      too_long_in  = too_long_ff;
      pp_in        = pp_ff;
      tp_in        = tp_ff;
      spp_in       = spp_ff;
      stp_in       = stp_ff;
      star_seen_in = star_seen_ff;
      aw_in        = aw_ff;
      res_match_in = res_match_ff;
      res_ovf_in   = res_ovf_ff;
      mem_we       = 1'b0;
      rsp_load     = 1'b0;
      mismatch     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata != CHAR_NUL) begin
                  if (count_ff < TW'(TEXT_MAX)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     too_long_in = 1'b1;
                  end
               end else if (too_long_ff) begin
                  res_match_in = 1'b0;
                  res_ovf_in   = 1'b1;
                  state_in     = ST_PUT;
               end else if (!pattern.enable) begin
                  res_match_in = 1'b1;
                  res_ovf_in   = 1'b0;
                  state_in     = ST_PUT;
               end else begin
                  res_ovf_in   = 1'b0;
                  pp_in        = '0;
                  tp_in        = '0;
                  spp_in       = '0;
                  stp_in       = '0;
                  star_seen_in = 1'b0;
                  aw_in        = 1'b0;
                  state_in     = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (pc == CHAR_STAR) begin
               pp_in        = pp_plus;
               spp_in       = pp_plus;
               stp_in       = tp_ff;
               star_seen_in = 1'b1;
               aw_in        = 1'b1;
               state_in     = ST_FETCH;
            end else if (pc == CHAR_QUEST) begin
               pp_in = pp_plus;
               if (!text_left) begin
                  res_match_in = 1'b0;
                  state_in     = ST_PUT;
               end else begin
                  tp_in    = tp_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end else if (pc == CHAR_BSLASH && qc == CHAR_NUL) begin
               res_match_in = 1'b0;
               state_in     = ST_PUT;
            end else begin
               if (epc == CHAR_NUL) begin
                  if (!text_left || aw_ff) begin
                     res_match_in = 1'b1;
                     state_in     = ST_PUT;
                  end else begin
                     mismatch = 1'b1;
                  end
               end else begin
                  aw_in = 1'b0;
                  if (to_lower(epc) != to_lower(tc)) begin
                     mismatch = 1'b1;
                  end else begin
                     pp_in    = epp + 1'b1;
                     tp_in    = tp_ff + 1'b1;
                     state_in = ST_FETCH;
                  end
               end
               if (mismatch) begin
                  if (!text_left || !star_seen_ff) begin
                     res_match_in = 1'b0;
                     state_in     = ST_PUT;
                  end else begin
                     pp_in    = spp_ff;
                     stp_in   = stp_ff + 1'b1;
                     tp_in    = stp_ff + 1'b1;
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load    = 1'b1;
               count_in    = '0;
               too_long_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         too_long_ff  <= 1'b0;
         pp_ff        <= '0;
         tp_ff        <= '0;
         spp_ff       <= '0;
         stp_ff       <= '0;
         star_seen_ff <= 1'b0;
         aw_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         too_long_ff  <= too_long_in;
         pp_ff        <= pp_in;
         tp_ff        <= tp_in;
         spp_ff       <= spp_in;
         stp_ff       <= stp_in;
         star_seen_ff <= star_seen_in;
         aw_ff        <= aw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_match_ff <= res_match_in;
      res_ovf_ff   <= res_ovf_in;
      if (rsp_load) begin
         rsp_match_ff <= res_match_ff;
         rsp_ovf_ff   <= res_ovf_ff;
      end
   end

   // text memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[count_ff[AW-1:0]] <= req_tdata;
      end
      if (state_ff == ST_FETCH) begin
         text_rd_ff <= text_mem[tp_ff[AW-1:0]];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ovf_ff, rsp_match_ff};

   `ASSERT_AT(a_text_pos_bound, clock, reset, (state_ff == ST_EVAL) |-> (tp_ff <= count_ff))
   `ASSERT_AT(a_too_long_full, clock, reset, too_long_ff |-> (count_ff == TW'(TEXT_MAX)))
   `ASSERT_NEVER(a_star_clear, clock, reset,
      (state_ff == ST_EVAL) && !star_seen_ff && (stp_ff != '0 || spp_ff != '0))

endmodule
